>>> rtl/gmb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Goertzel multi-bin package
// Shared sizes, register indexes, sequencer states and the request and
// response bundles of the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
package gmb_pkg;

  localparam int unsigned NUM_BINS   = 4;
  localparam int unsigned BIN_W      = 2;
  localparam int unsigned NB_W       = 3;
  localparam int unsigned MAX_LENGTH = 4096;
  localparam int unsigned LEN_W      = 13;
  localparam int unsigned SEEN_W     = 12;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned ACC_W      = 48;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned COEF_W     = 18;
  localparam int unsigned COEF_WORD_W = 2 * COEF_W;
  localparam int unsigned MUL_B_W    = COEF_W + 1;
  localparam int unsigned SLICE_W    = ACC_W / 2;
  localparam int unsigned MUL_A_W    = SLICE_W + 1;
  localparam int unsigned PROD_W     = MUL_A_W + MUL_B_W;
  localparam int unsigned WIDE_W     = PROD_W + SLICE_W;
  localparam int unsigned ADDEND_W   = ACC_W + 2;
  localparam int unsigned SUM_W      = WIDE_W - FRAC_W + 2;
  localparam int unsigned CFG_IDX_W  = 3;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BINS_IN_USE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIN0_COEF    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIN1_COEF    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BIN2_COEF    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BIN3_COEF    = 3'd5;

  localparam logic [LEN_W-1:0] LEN_RESET = 13'd256;
  localparam logic [NB_W-1:0]  NB_RESET  = 3'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPD_START,
    ST_UPD_WAIT,
    ST_RE_START,
    ST_RE_WAIT,
    ST_IM_START,
    ST_IM_WAIT,
    ST_EMIT
  } gmb_state_e;

  typedef enum logic [2:0] {
    MAC_IDLE,
    MAC_LO,
    MAC_HI,
    MAC_ADD,
    MAC_SAT
  } gmb_mac_phase_e;

  typedef struct packed {
    logic                start;
    logic [ACC_W-1:0]    q1;
    logic [MUL_B_W-1:0]  coef;
    logic [ADDEND_W-1:0] addend;
  } gmb_mac_req_t;

  typedef struct packed {
    logic             done;
    logic [ACC_W-1:0] result;
  } gmb_mac_rsp_t;

endpackage
`default_nettype wire

>>> rtl/gmb_mac.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Goertzel shared multiply-accumulate unit
// Forms sat(floor(q1 * coef / 2^16) + addend) with one 25x19 multiplier used
// on the two halves of q1 through the LO, HI, ADD and SAT phases after start.
// ----------------------------------------------------------------------------
module gmb_mac import gmb_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire gmb_mac_req_t req_i,
  output gmb_mac_rsp_t      rsp_o
);

  gmb_mac_phase_e phase_q, phase_d;

  logic [ACC_W-1:0]    a_q;
  logic [MUL_B_W-1:0]  coef_q;
  logic [ADDEND_W-1:0] addend_q;
  logic [PROD_W-1:0]   prod_q, prod_d;
  logic [WIDE_W-1:0]   acc_q, acc_d;

  logic [MUL_A_W-1:0]     mul_a;
  logic [SUM_W-3:0]       shifted;
  logic [SUM_W-1:0]       sum;
  logic [SUM_W-ACC_W:0]   top_bits;
  logic [ACC_W-1:0]       sat_val;

  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      MAC_IDLE: if (req_i.start) phase_d = MAC_LO;
      MAC_LO:   phase_d = MAC_HI;
      MAC_HI:   phase_d = MAC_ADD;
      MAC_ADD:  phase_d = MAC_SAT;
      MAC_SAT:  phase_d = MAC_IDLE;
      default:  phase_d = MAC_IDLE;
    endcase
  end

  // The low half of q1 enters as an unsigned slice, the high half signed.
  always_comb begin
    mul_a = '0;
    rsp_o = '0;
    unique case (phase_q)
      MAC_LO:  mul_a = {1'b0, a_q[SLICE_W-1:0]};
      MAC_HI:  mul_a = {a_q[ACC_W-1], a_q[ACC_W-1:SLICE_W]};
      MAC_SAT: rsp_o.done = 1'b1;
      default: mul_a = '0;
    endcase
    rsp_o.result = sat_val;
  end

  assign prod_d = PROD_W'($signed(mul_a)) * PROD_W'($signed(coef_q));

  always_comb begin
    acc_d = acc_q;
    if (phase_q == MAC_HI) begin
      acc_d = {{SLICE_W{prod_q[PROD_W-1]}}, prod_q};
    end else if (phase_q == MAC_ADD) begin
      acc_d = acc_q + {prod_q, {SLICE_W{1'b0}}};
    end
  end

  // Arithmetic shift by the fraction width, add, then clamp to 48 bits.
  assign shifted  = acc_q[WIDE_W-1:FRAC_W];
  assign sum      = {{2{shifted[SUM_W-3]}}, shifted}
                  + {{(SUM_W-ADDEND_W){addend_q[ADDEND_W-1]}}, addend_q};
  assign top_bits = sum[SUM_W-1:ACC_W-1];

  always_comb begin
    if ((&top_bits) || !(|top_bits)) begin
      sat_val = sum[ACC_W-1:0];
    end else if (sum[SUM_W-1]) begin
      sat_val = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(ACC_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= MAC_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (phase_q == MAC_IDLE && req_i.start) begin
      a_q      <= req_i.q1;
      coef_q   <= req_i.coef;
      addend_q <= req_i.addend;
    end
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

endmodule
`default_nettype wire

>>> rtl/goertzel_multi_bin.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Goertzel multi-bin engine
// Runs the Goertzel recurrence for up to four frequency bins on unsigned
// 16-bit samples and reports real and imaginary parts at the end of a block.
// ----------------------------------------------------------------------------
// Each accepted sample updates every bin in use through one shared 25x19
// multiplier that works on the two halves of the 48-bit delay value, one bin
// after another, and the next sample is accepted only once the last bin in
// use is updated. The sample that completes a block then takes each bin
// through the real and imaginary products and the loading of the output
// register, which waits while the output side stalls.
// Results leave in slot order, last_bin_o marks the final slot, and all
// delay state is cleared when that last result is loaded.
module goertzel_multi_bin import gmb_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [COEF_WORD_W-1:0] cfg_data_i,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [SAMPLE_W-1:0]    sample_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [BIN_W-1:0]            bin_slot_o,
  output logic signed [ACC_W-1:0]     real_part_o,
  output logic signed [ACC_W-1:0]     imag_part_o,
  output logic                        last_bin_o
);

  gmb_state_e state_q, state_d;

  logic [LEN_W-1:0]       block_length_q;
  logic [NB_W-1:0]        bins_in_use_q;
  logic [COEF_WORD_W-1:0] coef_q [NUM_BINS];

  logic [ACC_W-1:0]  d1_q [NUM_BINS];
  logic [ACC_W-1:0]  d2_q [NUM_BINS];
  logic [SEEN_W-1:0] seen_q;
  logic [BIN_W-1:0]  bin_q;
  logic [NB_W-1:0]   nb_q;
  logic [LEN_W-1:0]  len_q;
  logic [SAMPLE_W-1:0] x_q;
  logic [ACC_W-1:0]  real_q;
  logic [ACC_W-1:0]  imag_q;

  logic              out_valid_q;
  logic [BIN_W-1:0]  out_bin_q;
  logic [ACC_W-1:0]  out_real_q;
  logic [ACC_W-1:0]  out_imag_q;
  logic              out_last_q;

  gmb_mac_req_t mac_req;
  gmb_mac_rsp_t mac_rsp;

  logic [ACC_W-1:0]  q1, q2;
  logic [COEF_W-1:0] cos_w, sin_w;
  logic              in_fire, emit_load, bin_last, block_end;
  logic [NB_W-1:0]   nb_eff;
  logic [LEN_W-1:0]  len_eff;

  assign q1    = d1_q[bin_q];
  assign q2    = d2_q[bin_q];
  assign cos_w = coef_q[bin_q][COEF_W-1:0];
  assign sin_w = coef_q[bin_q][COEF_WORD_W-1:COEF_W];

  assign in_fire   = in_valid_i && in_ready_o;
  assign bin_last  = (({1'b0, bin_q} + NB_W'(1)) == nb_q);
  assign block_end = (({1'b0, seen_q} + LEN_W'(1)) >= len_q);

  // Out-of-range register values behave as the nearest legal setting.
  always_comb begin
    if (block_length_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (block_length_q > LEN_W'(MAX_LENGTH)) begin
      len_eff = LEN_W'(MAX_LENGTH);
    end else begin
      len_eff = block_length_q;
    end
    if (bins_in_use_q == '0) begin
      nb_eff = NB_W'(1);
    end else if (bins_in_use_q > NB_W'(NUM_BINS)) begin
      nb_eff = NB_W'(NUM_BINS);
    end else begin
      nb_eff = bins_in_use_q;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (in_fire) state_d = ST_UPD_START;
      ST_UPD_START: state_d = ST_UPD_WAIT;
      ST_UPD_WAIT: begin
        if (mac_rsp.done) begin
          if (!bin_last) begin
            state_d = ST_UPD_START;
          end else if (block_end) begin
            state_d = ST_RE_START;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_RE_START:  state_d = ST_RE_WAIT;
      ST_RE_WAIT:   if (mac_rsp.done) state_d = ST_IM_START;
      ST_IM_START:  state_d = ST_IM_WAIT;
      ST_IM_WAIT:   if (mac_rsp.done) state_d = ST_EMIT;
      ST_EMIT: begin
        if (emit_load) begin
          state_d = bin_last ? ST_IDLE : ST_RE_START;
        end
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o     = 1'b0;
    emit_load      = 1'b0;
    mac_req.start  = 1'b0;
    mac_req.q1     = q1;
    mac_req.coef   = {cos_w, 1'b0};
    mac_req.addend = {{(ADDEND_W-SAMPLE_W){1'b0}}, x_q}
                   - {{(ADDEND_W-ACC_W){q2[ACC_W-1]}}, q2};
    unique case (state_q)
      ST_IDLE:      in_ready_o = 1'b1;
      ST_UPD_START: mac_req.start = 1'b1;
      ST_RE_START: begin
        mac_req.start  = 1'b1;
        mac_req.coef   = {cos_w[COEF_W-1], cos_w};
        mac_req.addend = ADDEND_W'(0) - {{(ADDEND_W-ACC_W){q2[ACC_W-1]}}, q2};
      end
      ST_IM_START: begin
        mac_req.start  = 1'b1;
        mac_req.coef   = {sin_w[COEF_W-1], sin_w};
        mac_req.addend = '0;
      end
      ST_EMIT:      emit_load = !out_valid_q || out_ready_i;
      default:      in_ready_o = 1'b0;
    endcase
  end

  gmb_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mac_req),
    .rsp_o  (mac_rsp)
  );

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_length_q <= LEN_RESET;
      bins_in_use_q  <= NB_RESET;
      for (int i = 0; i < NUM_BINS; i++) begin
        coef_q[i] <= '0;
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_BLOCK_LENGTH: block_length_q <= cfg_data_i[LEN_W-1:0];
        REG_BINS_IN_USE:  bins_in_use_q  <= cfg_data_i[NB_W-1:0];
        REG_BIN0_COEF:    coef_q[0] <= cfg_data_i;
        REG_BIN1_COEF:    coef_q[1] <= cfg_data_i;
        REG_BIN2_COEF:    coef_q[2] <= cfg_data_i;
        REG_BIN3_COEF:    coef_q[3] <= cfg_data_i;
        default:          block_length_q <= block_length_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bin_q       <= '0;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_BINS; i++) begin
        d1_q[i] <= '0;
        d2_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        bin_q <= '0;
      end
      if (state_q == ST_UPD_WAIT && mac_rsp.done) begin
        d2_q[bin_q] <= q1;
        d1_q[bin_q] <= mac_rsp.result;
        if (!bin_last) begin
          bin_q <= bin_q + BIN_W'(1);
        end else if (block_end) begin
          bin_q <= '0;
        end else begin
          seen_q <= seen_q + SEEN_W'(1);
        end
      end
      if (emit_load) begin
        out_valid_q <= 1'b1;
        if (bin_last) begin
          // The last result of the block closes it: all slots start over.
          seen_q <= '0;
          for (int i = 0; i < NUM_BINS; i++) begin
            d1_q[i] <= '0;
            d2_q[i] <= '0;
          end
        end else begin
          bin_q <= bin_q + BIN_W'(1);
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_q   <= sample_i;
      nb_q  <= nb_eff;
      len_q <= len_eff;
    end
    if (state_q == ST_RE_WAIT && mac_rsp.done) begin
      real_q <= mac_rsp.result;
    end
    if (state_q == ST_IM_WAIT && mac_rsp.done) begin
      imag_q <= mac_rsp.result;
    end
    if (emit_load) begin
      out_bin_q  <= bin_q;
      out_real_q <= real_q;
      out_imag_q <= imag_q;
      out_last_q <= bin_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign bin_slot_o  = out_bin_q;
  assign real_part_o = out_real_q;
  assign imag_part_o = out_imag_q;
  assign last_bin_o  = out_last_q;

endmodule
`default_nettype wire

>>> rtl/gmb_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Goertzel multi-bin port checker
// Watches the top-level ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
module gmb_checker import gmb_pkg::*; (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   in_valid_i,
  input wire logic                   in_ready_o,
  input wire logic                   out_valid_o,
  input wire logic                   out_ready_i,
  input wire logic [BIN_W-1:0]       bin_slot_o,
  input wire logic [ACC_W-1:0]       real_part_o,
  input wire logic [ACC_W-1:0]       imag_part_o,
  input wire logic                   last_bin_o
);

  // A stalled result holds until its transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(bin_slot_o) && $stable(real_part_o)
       && $stable(imag_part_o) && $stable(last_bin_o)))
    else $error("result changed while stalled");

  // The engine is busy in the cycle after it takes a sample.
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("sample taken in the cycle after a sample transfer");

  // Only the last result of a block may still be waiting while samples are taken.
  a_partial_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_bin_o) |-> !in_ready_o)
    else $error("ready for samples while a block is still being reported");

  // A result that is not last is followed by the next slot in order.
  a_slot_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_bin_o) |=>
      (!out_valid_o || (bin_slot_o == $past(bin_slot_o) + BIN_W'(1))))
    else $error("result slots out of order");

endmodule

bind goertzel_multi_bin gmb_checker u_gmb_checker (.*);
`default_nettype wire

>>> bench/goertzel_multi_bin_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Goertzel multi-bin engine testbench
// Streams ADC samples into the engine under varied block lengths, bin counts
// and coefficients, predicts every bin result in fixed point and checks each
// result transfer field by field, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module goertzel_multi_bin_tb;
  import gmb_pkg::*;

  localparam int unsigned EXACT_W        = 80;
  localparam int unsigned SETTLE_CYCLES  = 80;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned RANDOM_PHASES  = 12;

  // Indexes past the last coefficient word; writes to them must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  localparam logic [COEF_W-1:0] COEF_MAX = 18'h1FFFF;
  localparam logic [COEF_W-1:0] COEF_MIN = 18'h20000;
  localparam logic [COEF_W-1:0] COEF_ONE = 18'h10000;

  localparam logic signed [EXACT_W-1:0] ACC_HI = {{(EXACT_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
  localparam logic signed [EXACT_W-1:0] ACC_LO = {{(EXACT_W-ACC_W+1){1'b1}}, {(ACC_W-1){1'b0}}};

  typedef enum int {
    PACE_FULL,
    PACE_SENDER_GAPS,
    PACE_RECEIVER_STALLS,
    PACE_BOTH
  } pace_e;

  typedef struct {
    logic [BIN_W-1:0]        slot;
    logic signed [ACC_W-1:0] re;
    logic signed [ACC_W-1:0] im;
    logic                    last;
  } bin_result_t;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i = REG_BLOCK_LENGTH;
  logic [COEF_WORD_W-1:0] cfg_data_i  = '0;
  logic                   in_valid_i  = 1'b0;
  logic [SAMPLE_W-1:0]    sample_i    = '0;
  logic                   out_ready_i = 1'b0;
  logic                   cfg_ready_o;
  logic                   in_ready_o;
  logic                   out_valid_o;
  logic [BIN_W-1:0]       bin_slot_o;
  logic signed [ACC_W-1:0] real_part_o;
  logic signed [ACC_W-1:0] imag_part_o;
  logic                   last_bin_o;

  goertzel_multi_bin DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .bin_slot_o  (bin_slot_o),
    .real_part_o (real_part_o),
    .imag_part_o (imag_part_o),
    .last_bin_o  (last_bin_o)
  );

  // Predicted engine state and registers.
  logic [LEN_W-1:0]        blk_len_reg;
  logic [NB_W-1:0]         bins_reg;
  logic [COEF_WORD_W-1:0]  coef_reg [NUM_BINS];
  logic signed [ACC_W-1:0] acc_one [NUM_BINS];
  logic signed [ACC_W-1:0] acc_two [NUM_BINS];
  int unsigned             seen_count;

  logic [SAMPLE_W-1:0] sample_queue [$];
  bin_result_t         expected_bins [$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          in_fire        = 1'b0;
  int unsigned idle_cycles    = 0;
  int unsigned failures       = 0;
  int unsigned samples_taken  = 0;
  int unsigned results_seen   = 0;
  int unsigned cfg_writes     = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic signed [EXACT_W-1:0] prod_floor(
    input logic signed [ACC_W-1:0] a, input logic signed [COEF_W+1:0] b);
    logic signed [EXACT_W-1:0] wa, wb, p;
    wa = EXACT_W'(a);
    wb = EXACT_W'(b);
    p  = wa * wb;
    return p >>> FRAC_W;
  endfunction

  function automatic logic signed [ACC_W-1:0] clamp_acc(input logic signed [EXACT_W-1:0] v);
    if (v > ACC_HI) return ACC_HI[ACC_W-1:0];
    if (v < ACC_LO) return ACC_LO[ACC_W-1:0];
    return v[ACC_W-1:0];
  endfunction

  task automatic clear_delays();
    int b;
    for (b = 0; b < NUM_BINS; b++) begin
      acc_one[b] = '0;
      acc_two[b] = '0;
    end
    seen_count = 0;
  endtask

  task automatic apply_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [COEF_WORD_W-1:0] data);
    case (idx) inside
      REG_BLOCK_LENGTH: blk_len_reg = data[LEN_W-1:0];
      REG_BINS_IN_USE:  bins_reg = data[NB_W-1:0];
      REG_BIN0_COEF, REG_BIN1_COEF, REG_BIN2_COEF, REG_BIN3_COEF: begin
        coef_reg[idx - REG_BIN0_COEF] = data;
      end
      default: ;
    endcase
  endtask

  // One Goertzel step per bin in use; at the end of a block, queue a result per bin.
  task automatic predict_bins(input logic [SAMPLE_W-1:0] x);
    int unsigned len, nb;
    int b;
    logic signed [COEF_W-1:0]   cosv, sinv;
    logic signed [COEF_W+1:0]   twice, cos_w, sin_w;
    logic signed [EXACT_W-1:0]  xw, back, acc;
    bin_result_t r;
    len = 32'(blk_len_reg);
    if (len == 0) len = 1;
    if (len > MAX_LENGTH) len = MAX_LENGTH;
    nb = 32'(bins_reg);
    if (nb == 0) nb = 1;
    if (nb > NUM_BINS) nb = NUM_BINS;
    xw = {{(EXACT_W-SAMPLE_W){1'b0}}, x};
    for (b = 0; b < nb; b++) begin
      cosv  = coef_reg[b][COEF_W-1:0];
      twice = (COEF_W+2)'(cosv);
      twice = twice <<< 1;
      back  = EXACT_W'(acc_two[b]);
      acc   = prod_floor(acc_one[b], twice) - back + xw;
      acc_two[b] = acc_one[b];
      acc_one[b] = clamp_acc(acc);
    end
    if (seen_count + 1 < len) begin
      seen_count++;
    end else begin
      for (b = 0; b < nb; b++) begin
        cosv   = coef_reg[b][COEF_W-1:0];
        sinv   = coef_reg[b][COEF_WORD_W-1:COEF_W];
        cos_w  = (COEF_W+2)'(cosv);
        sin_w  = (COEF_W+2)'(sinv);
        back   = EXACT_W'(acc_two[b]);
        r.slot = b[BIN_W-1:0];
        r.re   = clamp_acc(prod_floor(acc_one[b], cos_w) - back);
        r.im   = clamp_acc(prod_floor(acc_one[b], sin_w));
        r.last = (b + 1 == nb);
        expected_bins.push_back(r);
      end
      clear_delays();
    end
  endtask

  initial begin
    blk_len_reg = LEN_RESET;
    bins_reg    = NB_RESET;
    for (int b = 0; b < NUM_BINS; b++) coef_reg[b] = '0;
    clear_delays();
  end

  // Sample driver: one transfer at a time, gaps drawn per cycle.
  always @(negedge clk_i) begin
    logic                nv;
    logic [SAMPLE_W-1:0] ns;
    nv = in_valid_i;
    ns = sample_i;
    if (in_valid_i && in_fire) nv = 1'b0;
    if (!nv && rst_ni && sample_queue.size() > 0 &&
        $urandom_range(99) >= send_idle_pct) begin
      nv = 1'b1;
      ns = sample_queue.pop_front();
    end
    in_valid_i  <= nv;
    sample_i    <= ns;
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: predicts on sample and register transfers, checks result transfers.
  always @(posedge clk_i) begin
    bin_result_t want;
    bit cfg_fire, out_fire;
    in_fire  = rst_ni && in_valid_i && in_ready_o;
    cfg_fire = rst_ni && cfg_valid_i && cfg_ready_o;
    out_fire = rst_ni && out_valid_o && out_ready_i;
    if (cfg_fire) begin
      apply_register(cfg_index_i, cfg_data_i);
      cfg_writes++;
    end
    if (in_fire) begin
      predict_bins(sample_i);
      samples_taken++;
    end
    if (out_fire) begin
      results_seen++;
      if (expected_bins.size() == 0) begin
        $error("unexpected result transfer for slot %0d", bin_slot_o);
        failures++;
      end else begin
        want = expected_bins.pop_front();
        if (bin_slot_o !== want.slot) begin
          $error("bin_slot: expected %0d, got %0d", want.slot, bin_slot_o);
          failures++;
        end
        if (real_part_o !== want.re) begin
          $error("real_part: expected %0d, got %0d", want.re, real_part_o);
          failures++;
        end
        if (imag_part_o !== want.im) begin
          $error("imag_part: expected %0d, got %0d", want.im, imag_part_o);
          failures++;
        end
        if (last_bin_o !== want.last) begin
          $error("last_bin: expected %0d, got %0d", want.last, last_bin_o);
          failures++;
        end
      end
    end
    if (cfg_fire || in_fire || out_fire) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("goertzel_multi_bin_tb NOT OK");
      $finish;
    end
  end

  function automatic logic [COEF_WORD_W-1:0] rand_word();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[COEF_WORD_W-1:0];
  endfunction

  // Puts a register value in the low bits, with random junk above it half the time.
  function automatic logic [COEF_WORD_W-1:0] pad_field(input int unsigned value,
                                                       input int unsigned width);
    logic [COEF_WORD_W-1:0] mask, junk, v;
    mask = {COEF_WORD_W{1'b1}} << width;
    junk = $urandom_range(1) ? rand_word() : '0;
    v    = COEF_WORD_W'(value);
    return (junk & mask) | (v & ~mask);
  endfunction

  // Either any bit pattern or a plausible pair with magnitudes up to one.
  function automatic logic [COEF_WORD_W-1:0] random_coef_word();
    logic [COEF_W-1:0] c, s;
    if ($urandom_range(1)) begin
      c = COEF_W'($urandom);
      s = COEF_W'($urandom);
    end else begin
      c = COEF_W'($urandom_range(131072) - 65536);
      s = COEF_W'($urandom_range(131072) - 65536);
    end
    return {s, c};
  endfunction

  function automatic logic [SAMPLE_W-1:0] random_sample();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return SAMPLE_W'($urandom);
  endfunction

  task automatic set_pace(input pace_e pace);
    case (pace)
      PACE_FULL:            begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      PACE_SENDER_GAPS:     begin send_idle_pct = 58; recv_stall_pct = 0;  end
      PACE_RECEIVER_STALLS: begin send_idle_pct = 0;  recv_stall_pct = 58; end
      default:              begin send_idle_pct = 26; recv_stall_pct = 26; end
    endcase
  endtask

  // Leaves valid high so back-to-back writes keep one assignment per edge.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [COEF_WORD_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic cfg_done();
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Waits for all samples and results to transfer, then lets a non-ending
  // sample finish its bin updates before anything is reconfigured.
  task automatic settle();
    do @(posedge clk_i);
    while (sample_queue.size() != 0 || in_valid_i || expected_bins.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned p, s, n, pick, len;
    set_pace(PACE_FULL);
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero length acts as one; four bins, extreme coefficients on bins 0 and 1.
    cfg_write(REG_BLOCK_LENGTH, COEF_WORD_W'(0));
    cfg_write(REG_BINS_IN_USE, COEF_WORD_W'(4));
    cfg_write(REG_BIN0_COEF, {COEF_MIN, COEF_MAX});
    cfg_write(REG_BIN1_COEF, {COEF_MAX, COEF_MIN});
    cfg_write(REG_BIN2_COEF, {{COEF_W{1'b0}}, COEF_ONE});
    cfg_write(REG_BIN3_COEF, random_coef_word());
    cfg_done();
    sample_queue.push_back('1);
    sample_queue.push_back('0);
    settle();

    // Full-scale input with coefficients near plus and minus two on bins 0 and 1
    // drives their accumulators into saturation; a bin count above four acts as four.
    cfg_write(REG_BLOCK_LENGTH, COEF_WORD_W'(18));
    cfg_write(REG_BINS_IN_USE, COEF_WORD_W'(7));
    cfg_done();
    repeat (18) sample_queue.push_back('1);
    settle();

    // Longest block, then the length is cut to the number of samples already seen,
    // the coefficients change mid-block and spare indexes are written.
    cfg_write(REG_BLOCK_LENGTH, COEF_WORD_W'(MAX_LENGTH));
    cfg_write(REG_BINS_IN_USE, COEF_WORD_W'(0));
    cfg_done();
    repeat (2) sample_queue.push_back(random_sample());
    settle();
    cfg_write(REG_BLOCK_LENGTH, COEF_WORD_W'(2));
    cfg_write(REG_BIN0_COEF, random_coef_word());
    cfg_write(REG_SPARE_A, rand_word());
    cfg_write(REG_SPARE_B, rand_word());
    cfg_done();
    sample_queue.push_back(random_sample());
    settle();

    // A length above the maximum is clamped; then it is lowered to one.
    cfg_write(REG_BLOCK_LENGTH, COEF_WORD_W'({LEN_W{1'b1}}));
    cfg_done();
    sample_queue.push_back(random_sample());
    settle();
    cfg_write(REG_BLOCK_LENGTH, COEF_WORD_W'(1));
    cfg_done();
    sample_queue.push_back(random_sample());
    settle();

    for (p = 0; p < RANDOM_PHASES; p++) begin
      set_pace(pace_e'(p % 4));
      pick = $urandom_range(99);
      if (pick < 70) len = $urandom_range(8, 1);
      else if (pick < 92) len = $urandom_range(40, 9);
      else len = $urandom_range(1);
      cfg_write(REG_BLOCK_LENGTH, pad_field(len, LEN_W));
      cfg_write(REG_BINS_IN_USE, pad_field($urandom_range(7), NB_W));
      for (s = 0; s < NUM_BINS; s++) begin
        if (p == 0 || $urandom_range(99) < 60)
          cfg_write(CFG_IDX_W'(REG_BIN0_COEF + s), random_coef_word());
      end
      if ($urandom_range(4) == 0)
        cfg_write($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, rand_word());
      cfg_done();
      n = $urandom_range(32, 16);
      repeat (n) sample_queue.push_back(random_sample());
      settle();
    end

    if (expected_bins.size() != 0) begin
      $error("%0d bin results never arrived", expected_bins.size());
      failures++;
    end
    $display("Run covered %0d samples and %0d bin results with %0d register writes,",
             samples_taken, results_seen, cfg_writes);
    $display("over %0d random phases plus directed blocks; %0d mismatches.",
             RANDOM_PHASES, failures);
    if (failures == 0) begin
      $display("goertzel_multi_bin_tb OK");
    end else begin
      $display("goertzel_multi_bin_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> goertzel_multi_bin.f
rtl/gmb_pkg.sv
rtl/gmb_mac.sv
rtl/goertzel_multi_bin.sv
rtl/gmb_checker.sv
bench/goertzel_multi_bin_tb.sv
